// ----- rtl/tlc_pkg.sv -----
// Shared types, constants and helpers for the tilt to RGB level controller.
package tlc_pkg;

  localparam int LEVEL_W   = 8;
  localparam int RATE_W    = 16;
  localparam int TOUCH_W   = 16;
  localparam int THRESH_W  = 15;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 24;

  localparam int MAX_LEVEL_DEF = 255;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd2000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_THRESH   = 3'd0,
    REG_LOW_MIN  = 3'd1,
    REG_LOW_MAX  = 3'd2,
    REG_MID_MIN  = 3'd3,
    REG_MID_MAX  = 3'd4,
    REG_HIGH_MIN = 3'd5,
    REG_HIGH_MAX = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    SCALE_FULL  = 2'd0,
    SCALE_HALF  = 2'd1,
    SCALE_TENTH = 2'd2
  } scale_t;

  typedef struct packed {
    logic [THRESH_W-1:0] thresh;
    logic [TOUCH_W-1:0]  low_min;
    logic [TOUCH_W-1:0]  low_max;
    logic [TOUCH_W-1:0]  mid_min;
    logic [TOUCH_W-1:0]  mid_max;
    logic [TOUCH_W-1:0]  high_min;
    logic [TOUCH_W-1:0]  high_max;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    scale_t             scale;
  } lvl_state_t;

  // Exact for every 8-bit value: x / 10 == (x * 205) >> 11.
  function automatic logic [LEVEL_W-1:0] div10(input logic [LEVEL_W-1:0] x);
    logic [LEVEL_W+10:0] prod;
    prod = {11'd0, x} * 19'd205;
    return prod[LEVEL_W+10:11];
  endfunction

endpackage

// ----- rtl/tilt_to_rgb_level_controller_top.sv -----
// An accepted transaction is held in the input register, then its result in the result
// register for the master side. Throughput: one transaction per cycle while results are
// taken; with two stages, the input side still takes one transaction while a result stalls.
// Reset (rst, synchronous, active high): levels clear, divisor returns to one,
// threshold returns to 2000, band bounds clear, both stages empty.
module tilt_to_rgb_level_controller_top
  import tlc_pkg::*;
#(
  parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // rate_x [15:0], rate_y [31:16], rate_z [47:32], touch_value [63:48]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // red_drive [7:0], green_drive [15:8], blue_drive [23:16]
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  cfg_t       cfg;
  lvl_state_t st;
  lvl_state_t st_next;

  logic                  in_valid;
  logic [IN_TDATA_W-1:0] in_data;
  logic                  advance;

  logic [LEVEL_W-1:0] red_drive, green_drive, blue_drive;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thresh   <= THRESH_RESET;
      cfg.low_min  <= '0;
      cfg.low_max  <= '0;
      cfg.mid_min  <= '0;
      cfg.mid_max  <= '0;
      cfg.high_min <= '0;
      cfg.high_max <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_THRESH:   cfg.thresh   <= cfg_wdata[THRESH_W-1:0];
        REG_LOW_MIN:  cfg.low_min  <= cfg_wdata;
        REG_LOW_MAX:  cfg.low_max  <= cfg_wdata;
        REG_MID_MIN:  cfg.mid_min  <= cfg_wdata;
        REG_MID_MAX:  cfg.mid_max  <= cfg_wdata;
        REG_HIGH_MIN: cfg.high_min <= cfg_wdata;
        REG_HIGH_MAX: cfg.high_max <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_data <= s_tdata;
    end
  end

  tlc_step #(
    .MAX_LEVEL(MAX_LEVEL)
  ) u_step (
    .cfg         (cfg),
    .cur         (st),
    .rate_x      ($signed(in_data[15:0])),
    .rate_y      ($signed(in_data[31:16])),
    .rate_z      ($signed(in_data[47:32])),
    .touch_value (in_data[63:48]),
    .nxt         (st_next),
    .red_drive   (red_drive),
    .green_drive (green_drive),
    .blue_drive  (blue_drive)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.red   <= '0;
      st.green <= '0;
      st.blue  <= '0;
      st.scale <= SCALE_FULL;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {blue_drive, green_drive, red_drive};
    end
  end

`ifndef NO_ASSERTIONS
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    st.red <= LEVEL_W'(MAX_LEVEL) && st.green <= LEVEL_W'(MAX_LEVEL)
      && st.blue <= LEVEL_W'(MAX_LEVEL))
    else $error("colour level above maximum");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(st))
    else $error("level state changed without a transaction");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && m_tvalid && !m_tready |=> in_valid && $stable(in_data))
    else $error("input stage lost a transaction");

  a_result_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("result not presented after advance");
`endif

endmodule

// ----- rtl/tlc_step.sv -----
// Level stepping, brightness band selection and drive scaling for one transaction.
module tlc_step
  import tlc_pkg::*;
#(
  parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
  input  cfg_t                    cfg,
  input  lvl_state_t              cur,
  input  logic signed [RATE_W-1:0] rate_x,
  input  logic signed [RATE_W-1:0] rate_y,
  input  logic signed [RATE_W-1:0] rate_z,
  input  logic [TOUCH_W-1:0]      touch_value,
  output lvl_state_t              nxt,
  output logic [LEVEL_W-1:0]      red_drive,
  output logic [LEVEL_W-1:0]      green_drive,
  output logic [LEVEL_W-1:0]      blue_drive
);

  localparam logic [LEVEL_W-1:0] MAX_LVL = LEVEL_W'(MAX_LEVEL);

  logic signed [RATE_W:0] thr_pos;
  logic signed [RATE_W:0] thr_neg;

  assign thr_pos = $signed({2'b00, cfg.thresh});
  assign thr_neg = -thr_pos;

  function automatic logic [LEVEL_W-1:0] step(input logic [LEVEL_W-1:0] lvl,
                                              input logic signed [RATE_W-1:0] r,
                                              input logic signed [RATE_W:0] tp,
                                              input logic signed [RATE_W:0] tn);
    logic signed [RATE_W:0] rx;
    rx = {r[RATE_W-1], r};
    if (rx > tp && lvl < MAX_LVL) begin
      return lvl + 1'b1;
    end else if (rx < tn && lvl != '0) begin
      return lvl - 1'b1;
    end
    return lvl;
  endfunction

  function automatic logic [LEVEL_W-1:0] scale_lvl(input logic [LEVEL_W-1:0] lvl,
                                                   input scale_t s);
    case (s)
      SCALE_HALF:  return lvl >> 1;
      SCALE_TENTH: return div10(lvl);
      default:     return lvl;
    endcase
  endfunction

  logic in_low, in_mid, in_high;

  assign in_low  = touch_value > cfg.low_min  && touch_value < cfg.low_max;
  assign in_mid  = touch_value > cfg.mid_min  && touch_value < cfg.mid_max;
  assign in_high = touch_value > cfg.high_min && touch_value < cfg.high_max;

  always_comb begin
    nxt.red   = step(cur.red,   rate_x, thr_pos, thr_neg);
    nxt.green = step(cur.green, rate_y, thr_pos, thr_neg);
    nxt.blue  = step(cur.blue,  rate_z, thr_pos, thr_neg);
    if (in_low) begin
      nxt.scale = SCALE_TENTH;
    end else if (in_mid) begin
      nxt.scale = SCALE_HALF;
    end else if (in_high) begin
      nxt.scale = SCALE_FULL;
    end else begin
      nxt.scale = cur.scale;
    end
  end

  assign red_drive   = scale_lvl(nxt.red,   nxt.scale);
  assign green_drive = scale_lvl(nxt.green, nxt.scale);
  assign blue_drive  = scale_lvl(nxt.blue,  nxt.scale);

endmodule
